### sv/adjacency_edge_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the adjacency edge table
// Each macro expands to a labeled concurrent assertion, or to nothing when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ADJACENCY_EDGE_TABLE_ASSERT_SVH
`define ADJACENCY_EDGE_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define AET_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: label");
`define AET_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed: label");
`else
`define AET_ASSERT_IMPL(label, clk, rst_n, prop)
`define AET_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

### sv/aet_pkg.sv
// ----------------------------------------------------------------------------
// aet_pkg
// Types and codes shared by the adjacency edge table modules.
// ----------------------------------------------------------------------------
package aet_pkg;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_UPDATE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DEG_RD,
        S_CHECK,
        S_FIND_RD,
        S_FIND_CMP,
        S_FILT_RD,
        S_FILT_WR,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_HEAD_WR,
        S_KEY_RD,
        S_KEY_LATCH,
        S_ERASE_RD,
        S_ERASE_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [7:0]  nbr;
        logic [31:0] wa;
        logic [31:0] wb;
    } entry_t;

endpackage

### sv/aet_entry_ram.sv
// ----------------------------------------------------------------------------
// aet_entry_ram
// Simple dual-port entry store: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module aet_entry_ram #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [ADDR_W-1:0]     waddr,
    input  aet_pkg::entry_t       wdata,
    input  logic [ADDR_W-1:0]     raddr,
    output aet_pkg::entry_t       rdata
);
    import aet_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### sv/adjacency_edge_table.sv
// ----------------------------------------------------------------------------
// adjacency_edge_table
// Weighted neighbour lists per vertex, newest first, with a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: request beats. tdata = {weight_b_in, weight_a_in, target_vertex,
//   source_vertex, op}, op in bit 0. One request is taken at a time; tready
//   stays low until its answer beat has left the output register.
//   m_axis: answer beats. tdata = {weight_b_out, weight_a_out, status}.
//   Write directed_mode through cfg_we/cfg_wdata only while idle (not enforced).
// Datapath: list entries go through one entry RAM with a write port and a
//   registered read port; list degrees sit in a small RAM read in S_DEG_RD,
//   ahead of each pass. Lookup scans a list until the match. Insert shifts
//   each list touched down and writes the new head; remove finds the match
//   and filters the list from the match on; update erases then pushes.
// Reset: directed_mode clears and a pass over all degree entries (at most 256)
//   zeroes the degree RAM with tready low; the entry RAM is not cleared, since
//   only positions below a list's degree are read.
// Stall: the answer holds in the output register; no request until it leaves.
// ----------------------------------------------------------------------------
module adjacency_edge_table #(
    parameter int NUM_VERTICES = 256,
    parameter int MAX_DEGREE   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op[1:0], source_vertex[9:2], target_vertex[17:10], weight_a_in[49:18],
    // weight_b_in[81:50], zero[87:82]
    input  logic [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], weight_a_out[33:2], weight_b_out[65:34], zero[71:66]
    output logic [71:0] m_axis_tdata
);
    import aet_pkg::*;
    `include "adjacency_edge_table_assert.svh"

    localparam int VW    = 8;
    localparam int PW    = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int DW    = $clog2(MAX_DEGREE + 1);
    localparam int DEPTH = NUM_VERTICES * MAX_DEGREE;
    localparam int AW    = $clog2(DEPTH);
    localparam int NV    = (NUM_VERTICES < 256) ? NUM_VERTICES : 256;
    localparam int NVW   = (NV > 1) ? $clog2(NV) : 1;

    // Request registers
    op_t          op_reg, op_next;
    logic [VW-1:0] v1_reg, v1_next, v2_reg, v2_next;
    logic [31:0]  wa_reg, wa_next, wb_reg, wb_next;
    logic         dir_reg;

    // Sequencer registers
    state_t       state_reg, state_next;
    logic [VW-1:0] cv_reg, cv_next;      // current list vertex
    logic [VW-1:0] ct_reg, ct_next;      // neighbour searched / pushed
    logic         pass2_reg, pass2_next; // working on the target list
    logic [DW-1:0] p_reg, p_next;        // read position
    logic [DW-1:0] w_reg, w_next;        // write position
    entry_t       key_reg, key_next;

    // Degree RAM, cleared by a pass after reset
    logic [DW-1:0]  deg_mem [NV];
    logic [DW-1:0]  deg_a_reg, deg_b_reg; // degrees of cv and ct
    logic [DW-1:0]  cdeg_reg;             // degree of the list being worked
    logic [NVW-1:0] clr_reg, clr_next;
    logic           deg_we;
    logic [DW-1:0]  deg_wval;

    // Output register
    logic         ov_reg, ov_next;
    status_t      st_reg, st_next;
    logic [31:0]  oa_reg, oa_next, ob_reg, ob_next;

    // RAM port
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    entry_t        ram_wdata, ram_rdata;

    aet_entry_ram #(.DEPTH(DEPTH), .ADDR_W(AW)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    function automatic logic [AW-1:0] slot_addr(logic [VW-1:0] v, logic [DW-1:0] p);
        logic [AW+VW+DW-1:0] full;
        full = (AW+VW+DW)'(v) * (AW+VW+DW)'(MAX_DEGREE) + (AW+VW+DW)'(p);
        return full[AW-1:0];
    endfunction

    logic          accept;
    logic [DW-1:0] cdeg;
    logic          in_range;
    logic          ins_ok;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && !ov_reg;
    assign cdeg          = (state_reg == S_CHECK) ? deg_a_reg : cdeg_reg;
    assign in_range      = (32'(v1_reg) < 32'(NUM_VERTICES))
                        && (32'(v2_reg) < 32'(NUM_VERTICES));

    always_comb
    begin
        logic [DW:0] d1, d2;
        d1 = (DW+1)'(deg_a_reg);
        d2 = (DW+1)'(deg_b_reg);
        if (dir_reg)
            ins_ok = d1 < (DW+1)'(MAX_DEGREE);
        else if (v1_reg == v2_reg)
            ins_ok = (d1 + (DW+1)'(2)) <= (DW+1)'(MAX_DEGREE);
        else
            ins_ok = (d1 < (DW+1)'(MAX_DEGREE)) && (d2 < (DW+1)'(MAX_DEGREE));
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:     if (clr_reg == NVW'(NV - 1)) state_next = S_IDLE;
            S_IDLE:      if (accept) state_next = S_DEG_RD;
            S_DEG_RD:    state_next = S_CHECK;
            S_CHECK:
            begin
                // target pass of an insert was cleared by the source pass
                if (!in_range)
                    state_next = S_DONE;
                else if (op_reg == OP_INSERT)
                    state_next = (ins_ok || pass2_reg)
                               ? ((cdeg == '0) ? S_HEAD_WR : S_SHIFT_RD) : S_DONE;
                else
                    state_next = (cdeg == '0) ? S_DONE : S_FIND_RD;
            end
            S_FIND_RD:   state_next = S_FIND_CMP;
            S_FIND_CMP:
            begin
                if (ram_rdata.nbr == ct_reg)
                begin
                    unique case (op_reg)
                        OP_REMOVE: state_next = S_KEY_LATCH;
                        OP_UPDATE: state_next = S_ERASE_RD;
                        default:   state_next = S_DONE;
                    endcase
                end
                else if (p_reg + DW'(1) >= cdeg)
                    state_next = (op_reg == OP_REMOVE && pass2_reg) ? S_DONE : S_DONE;
                else
                    state_next = S_FIND_RD;
            end
            S_KEY_LATCH: state_next = S_KEY_RD;
            S_KEY_RD:    state_next = S_FILT_RD;
            S_FILT_RD:   state_next = S_FILT_WR;
            S_FILT_WR:   state_next = (p_reg + DW'(1) >= cdeg) ? S_DONE : S_FILT_RD;
            S_ERASE_RD:  state_next = S_ERASE_WR;
            S_ERASE_WR:  state_next = S_SHIFT_RD;
            S_SHIFT_RD:  state_next = S_SHIFT_WR;
            S_SHIFT_WR:  state_next = (p_reg == DW'(1)) ? S_HEAD_WR : S_SHIFT_RD;
            S_HEAD_WR:   state_next = S_DONE;
            S_DONE:      state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
        // Pass chaining and the erase and missed-match exits are handled here via overrides after the case
        if (state_reg == S_FIND_CMP && ram_rdata.nbr != ct_reg
            && p_reg + DW'(1) >= cdeg && pass2_reg)
            state_next = S_DONE;
        if (state_reg == S_ERASE_RD && p_reg + DW'(1) >= cdeg)
            state_next = (cdeg == DW'(1)) ? S_HEAD_WR : S_SHIFT_RD;
        if (state_reg == S_ERASE_WR && p_reg + DW'(2) < cdeg)
            state_next = S_ERASE_RD;
        if (state_reg == S_FILT_WR && p_reg + DW'(1) >= cdeg
            && !pass2_reg && !dir_reg)
            state_next = S_DEG_RD;
        if (state_reg == S_HEAD_WR && op_reg == OP_INSERT && !pass2_reg && !dir_reg)
            state_next = S_DEG_RD;
    end

    // Datapath and outputs
    always_comb
    begin
        logic fin;
        op_next = op_reg; v1_next = v1_reg; v2_next = v2_reg;
        wa_next = wa_reg; wb_next = wb_reg;
        cv_next = cv_reg; ct_next = ct_reg; pass2_next = pass2_reg;
        p_next = p_reg; w_next = w_reg; key_next = key_reg;
        ov_next = ov_reg; st_next = st_reg; oa_next = oa_reg; ob_next = ob_reg;
        clr_next = clr_reg;
        ram_we = 1'b0; ram_waddr = slot_addr(cv_reg, w_reg); ram_wdata = ram_rdata;
        ram_raddr = slot_addr(cv_reg, p_reg);
        deg_we = 1'b0; deg_wval = cdeg;
        fin = 1'b0;
        if (ov_reg && m_axis_tready)
            ov_next = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + NVW'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next = op_t'(s_axis_tdata[1:0]);
                    v1_next = s_axis_tdata[9:2];
                    v2_next = s_axis_tdata[17:10];
                    wa_next = s_axis_tdata[49:18];
                    wb_next = s_axis_tdata[81:50];
                    cv_next = s_axis_tdata[9:2];
                    ct_next = s_axis_tdata[17:10];
                    pass2_next = 1'b0;
                    st_next = ST_NOTFOUND;
                    oa_next = '0; ob_next = '0;
                end
            end
            S_DEG_RD: ;
            S_CHECK:
            begin
                p_next = '0; w_next = '0;
                if (in_range && op_reg == OP_INSERT)
                begin
                    if (!pass2_reg)
                        st_next = ins_ok ? ST_OK : ST_FULL;
                    p_next = cdeg;
                end
            end
            S_FIND_RD: ;
            S_FIND_CMP:
            begin
                if (ram_rdata.nbr == ct_reg)
                begin
                    if (!pass2_reg) st_next = ST_OK;
                    if (op_reg == OP_LOOKUP)
                    begin
                        oa_next = ram_rdata.wa; ob_next = ram_rdata.wb;
                    end
                    key_next = ram_rdata;
                    w_next = p_reg;
                end
                else
                    p_next = p_reg + DW'(1);
            end
            S_KEY_LATCH:
            begin
                // restart filter at the match; entries before it stay
                ram_raddr = slot_addr(cv_reg, p_reg);
            end
            S_KEY_RD: ;
            S_FILT_RD: ;
            S_FILT_WR:
            begin
                if (!(ram_rdata == key_reg))
                begin
                    ram_we = 1'b1;
                    ram_wdata = ram_rdata;
                    w_next = w_reg + DW'(1);
                end
                p_next = p_reg + DW'(1);
                ram_raddr = slot_addr(cv_reg, p_reg + DW'(1));
                if (p_reg + DW'(1) >= cdeg)
                begin
                    deg_we = 1'b1;
                    deg_wval = (ram_rdata == key_reg) ? w_reg : w_reg + DW'(1);
                    if (!pass2_reg && !dir_reg)
                    begin
                        pass2_next = 1'b1;
                        cv_next = v2_reg; ct_next = v1_reg;
                    end
                end
            end
            S_ERASE_RD:
            begin
                ram_raddr = slot_addr(cv_reg, p_reg + DW'(1));
                if (p_reg + DW'(1) >= cdeg)
                begin
                    deg_we = 1'b1;
                    deg_wval = cdeg - DW'(1);
                    p_next = cdeg - DW'(1);
                    w_next = cdeg - DW'(1);
                end
            end
            S_ERASE_WR:
            begin
                ram_we = 1'b1;
                ram_waddr = slot_addr(cv_reg, p_reg);
                ram_wdata = ram_rdata;
                p_next = p_reg + DW'(1);
                if (p_reg + DW'(2) >= cdeg)
                begin
                    deg_we = 1'b1;
                    deg_wval = cdeg - DW'(1);
                    p_next = cdeg - DW'(1);
                end
            end
            S_SHIFT_RD:
            begin
                ram_raddr = slot_addr(cv_reg, p_reg - DW'(1));
            end
            S_SHIFT_WR:
            begin
                ram_we = 1'b1;
                ram_waddr = slot_addr(cv_reg, p_reg);
                ram_wdata = ram_rdata;
                p_next = p_reg - DW'(1);
            end
            S_HEAD_WR:
            begin
                ram_we = 1'b1;
                ram_waddr = slot_addr(cv_reg, '0);
                ram_wdata.nbr = ct_reg;
                ram_wdata.wa = wa_reg;
                ram_wdata.wb = wb_reg;
                deg_we = 1'b1;
                deg_wval = cdeg + DW'(1);
                if (op_reg == OP_INSERT && !pass2_reg && !dir_reg)
                begin
                    pass2_next = 1'b1;
                    cv_next = v2_reg; ct_next = v1_reg;
                end
            end
            S_DONE:
            begin
                fin = 1'b1;
            end
            default: ;
        endcase
        // Filter starts reading at the match position
        if (state_reg == S_KEY_LATCH || state_reg == S_KEY_RD)
        begin
            ram_raddr = slot_addr(cv_reg, p_reg);
        end
        if (fin)
            ov_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
            dir_reg   <= 1'b0;
            pass2_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
            pass2_reg <= pass2_next;
            if (cfg_we)
                dir_reg <= cfg_wdata;
        end
    end

    // Degree RAM: one write, two registered reads (current list and target)
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
            deg_mem[clr_reg] <= '0;
        else if (deg_we)
            deg_mem[cv_reg[NVW-1:0]] <= deg_wval;
        deg_a_reg <= deg_mem[cv_reg[NVW-1:0]];
        deg_b_reg <= deg_mem[ct_reg[NVW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next; v1_reg <= v1_next; v2_reg <= v2_next;
        wa_reg <= wa_next; wb_reg <= wb_next;
        cv_reg <= cv_next; ct_reg <= ct_next;
        p_reg <= p_next; w_reg <= w_next;
        key_reg <= key_next;
        st_reg <= st_next; oa_reg <= oa_next; ob_reg <= ob_next;
        cdeg_reg <= deg_we ? deg_wval : cdeg;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {6'd0, ob_reg, oa_reg, st_reg};

    `AET_ASSERT_NEXT(a_busy_no_ready, clk, rst_n, accept, !s_axis_tready)
    `AET_ASSERT_IMPL(a_full_only_insert, clk, rst_n,
        !(m_axis_tvalid && st_reg == ST_FULL) || op_reg == OP_INSERT)
    `AET_ASSERT_IMPL(a_weights_zero, clk, rst_n,
        !(m_axis_tvalid && st_reg != ST_OK) || (oa_reg == '0 && ob_reg == '0))
endmodule
